@@ sv/rctc_pkg.sv @@
// Package for the relay cycle tester controller: sizes, register indexes,
// state and result structs, and the timer helper functions.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package rctc_pkg;

  localparam int COUNT_BITS    = 32;
  localparam int TIMER_BITS    = 16;
  localparam int MS_PER_SECOND = 1000;

  localparam int CFG_BITS    = 16;
  localparam int PERIOD_BITS = 6;
  localparam int OUT_COUNT_BITS = 32;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [31:0] TIMER_MAX_W = 32'((64'd1 << TIMER_BITS) - 64'd1);

  typedef enum logic [2:0] {
    REG_PULSE_MS          = 3'd0,
    REG_BUTTON_GUARD_MS   = 3'd1,
    REG_ADJUST_HOLDOFF_MS = 3'd2,
    REG_REED_GUARD_MS     = 3'd3,
    REG_STUCK_TIMEOUT_MS  = 3'd4,
    REG_CLEAR_HOLD_MS     = 3'd5,
    REG_SAVE_DELAY_MS     = 3'd6,
    REG_MAX_PERIOD_S      = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_BITS-1:0]    pulse_ms;
    logic [CFG_BITS-1:0]    button_guard_ms;
    logic [CFG_BITS-1:0]    adjust_holdoff_ms;
    logic [CFG_BITS-1:0]    reed_guard_ms;
    logic [CFG_BITS-1:0]    stuck_timeout_ms;
    logic [CFG_BITS-1:0]    clear_hold_ms;
    logic [CFG_BITS-1:0]    save_delay_ms;
    logic [PERIOD_BITS-1:0] max_period_s;
  } cfg_t;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] period;
    logic                   relay;
    logic                   phase_armed;
    logic [COUNT_BITS-1:0]  relay_cnt;
    logic [COUNT_BITS-1:0]  reed_cnt;
    logic [TIMER_BITS-1:0]  phase_t;
    logic [TIMER_BITS-1:0]  plus_guard_t;
    logic [TIMER_BITS-1:0]  minus_guard_t;
    logic                   plus_lock;
    logic                   minus_lock;
    logic [TIMER_BITS-1:0]  adjust_t;
    logic [TIMER_BITS-1:0]  reed_guard_t;
    logic                   reed_lock;
    logic [TIMER_BITS-1:0]  stuck_t;
    logic                   stuck_armed;
    logic                   fault;
    logic [TIMER_BITS-1:0]  hold_t;
    logic [TIMER_BITS-1:0]  save_t;
    logic                   save_pending;
  } state_t;

  typedef struct packed {
    logic                      relay_on;
    logic [OUT_COUNT_BITS-1:0] relay_count;
    logic [OUT_COUNT_BITS-1:0] reed_count;
    logic [PERIOD_BITS-1:0]    period_s;
    logic                      stuck_fault;
    logic                      save_strobe;
  } result_t;

  // Load a countdown timer, saturating at the largest timer value.
  function automatic logic [TIMER_BITS-1:0] sat_load(input logic [31:0] v);
    sat_load = (v > TIMER_MAX_W) ? TIMER_MAX : v[TIMER_BITS-1:0];
  endfunction

  // One millisecond of countdown, stopping at zero.
  function automatic logic [TIMER_BITS-1:0] count_down(input logic [TIMER_BITS-1:0] t);
    count_down = (t == '0) ? '0 : t - TIMER_BITS'(1);
  endfunction

endpackage

`default_nettype wire

@@ sv/rctc_cfg_regs.sv @@
// Configuration register file of the relay cycle tester controller.
// Depends on rctc_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module rctc_cfg_regs
  import rctc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_ms          <= CFG_BITS'(500);
      cfg.button_guard_ms   <= CFG_BITS'(200);
      cfg.adjust_holdoff_ms <= CFG_BITS'(5000);
      cfg.reed_guard_ms     <= CFG_BITS'(500);
      cfg.stuck_timeout_ms  <= CFG_BITS'(5000);
      cfg.clear_hold_ms     <= CFG_BITS'(5000);
      cfg.save_delay_ms     <= CFG_BITS'(4000);
      cfg.max_period_s      <= PERIOD_BITS'(30);
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        REG_PULSE_MS:          cfg.pulse_ms          <= cfg_data;
        REG_BUTTON_GUARD_MS:   cfg.button_guard_ms   <= cfg_data;
        REG_ADJUST_HOLDOFF_MS: cfg.adjust_holdoff_ms <= cfg_data;
        REG_REED_GUARD_MS:     cfg.reed_guard_ms     <= cfg_data;
        REG_STUCK_TIMEOUT_MS:  cfg.stuck_timeout_ms  <= cfg_data;
        REG_CLEAR_HOLD_MS:     cfg.clear_hold_ms     <= cfg_data;
        REG_SAVE_DELAY_MS:     cfg.save_delay_ms     <= cfg_data;
        REG_MAX_PERIOD_S:      cfg.max_period_s      <= cfg_data[PERIOD_BITS-1:0];
        default:               cfg.pulse_ms          <= cfg.pulse_ms;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/rctc_step.sv @@
// Next-state logic for one millisecond tick of the relay cycle tester.
// Purely combinational; depends on rctc_pkg for the structs and timer helpers.
`default_nettype none

module rctc_step
  import rctc_pkg::*;
(
  input  wire cfg_t   cfg,
  input  wire state_t cur,
  input  wire logic   plus,
  input  wire logic   minus,
  input  wire logic   reed,
  output state_t      nxt,
  output result_t     res
);

  logic                 save_due;
  logic                 strobe;
  logic [PERIOD_BITS:0] period_up;
  logic [31:0]          off_ms;

  always_comb begin
    save_due  = cur.save_pending && (cur.save_t == '0);
    strobe    = 1'b0;
    period_up = '0;
    off_ms    = '0;
    nxt       = cur;

    nxt.phase_t       = count_down(cur.phase_t);
    nxt.plus_guard_t  = count_down(cur.plus_guard_t);
    nxt.minus_guard_t = count_down(cur.minus_guard_t);
    nxt.adjust_t      = count_down(cur.adjust_t);
    nxt.reed_guard_t  = count_down(cur.reed_guard_t);
    nxt.stuck_t       = count_down(cur.stuck_t);
    nxt.save_t        = count_down(cur.save_t);

    if (minus && cur.hold_t != '0) begin
      // Minus is being held: only timers run, and the hold may clear.
      if (nxt.hold_t != TIMER_MAX) begin
        nxt.hold_t = nxt.hold_t + TIMER_BITS'(1);
      end
      if (32'(nxt.hold_t) >= 32'(cfg.clear_hold_ms)) begin
        nxt.period    = '0;
        nxt.relay_cnt = '0;
        nxt.reed_cnt  = '0;
        nxt.hold_t    = '0;
      end
    end else if (!(cur.fault && reed && cur.period != '0)) begin
      // Buttons.
      if (plus && !cur.plus_lock) begin
        period_up = {1'b0, cur.period} + (PERIOD_BITS+1)'(1);
        nxt.period = (period_up > {1'b0, cfg.max_period_s}) ? cfg.max_period_s
                                                             : period_up[PERIOD_BITS-1:0];
        nxt.plus_guard_t = sat_load(32'(cfg.button_guard_ms));
        nxt.plus_lock    = 1'b1;
        nxt.adjust_t     = sat_load(32'(cfg.adjust_holdoff_ms));
        nxt.save_t       = sat_load(32'(cfg.save_delay_ms));
        nxt.save_pending = 1'b1;
        save_due         = 1'b0;
      end
      if (nxt.plus_guard_t == '0 && !plus) begin
        nxt.plus_lock = 1'b0;
      end
      if (minus && !cur.minus_lock) begin
        nxt.period = (nxt.period != '0) ? nxt.period - PERIOD_BITS'(1) : '0;
        nxt.minus_guard_t = sat_load(32'(cfg.button_guard_ms));
        nxt.minus_lock    = 1'b1;
        nxt.adjust_t      = sat_load(32'(cfg.adjust_holdoff_ms));
        nxt.save_t        = sat_load(32'(cfg.save_delay_ms));
        nxt.save_pending  = 1'b1;
        save_due          = 1'b0;
      end
      if (nxt.minus_guard_t == '0) begin
        nxt.minus_lock = 1'b0;
      end
      if (nxt.period > cfg.max_period_s) begin
        nxt.period = cfg.max_period_s;
      end

      // Reed counting, once per relay cycle.
      if (reed && nxt.reed_guard_t == '0 && nxt.period != '0 && nxt.adjust_t == '0 &&
          !nxt.reed_lock) begin
        nxt.reed_cnt     = nxt.reed_cnt + COUNT_BITS'(1);
        nxt.reed_guard_t = sat_load(32'(cfg.reed_guard_ms));
        nxt.reed_lock    = 1'b1;
      end

      // Stuck supervision.
      if (reed && !nxt.stuck_armed && nxt.period != '0) begin
        nxt.stuck_t     = sat_load(32'(cfg.stuck_timeout_ms));
        nxt.stuck_armed = 1'b1;
      end else if (!reed) begin
        nxt.stuck_t     = '0;
        nxt.stuck_armed = 1'b0;
        nxt.fault       = 1'b0;
      end
      if (reed && nxt.stuck_armed && nxt.stuck_t == '0) begin
        nxt.fault = 1'b1;
      end

      if (!(nxt.fault && reed && nxt.period != '0)) begin
        // Relay sequencing.
        if (!nxt.phase_armed) begin
          off_ms = 32'(nxt.period) * 32'(MS_PER_SECOND);
          nxt.phase_t = nxt.relay ? sat_load(32'(cfg.pulse_ms)) : sat_load(off_ms);
          nxt.phase_armed = 1'b1;
        end
        if (!nxt.relay && nxt.phase_t == '0 && nxt.period != '0 && nxt.adjust_t == '0) begin
          nxt.relay       = 1'b1;
          nxt.phase_armed = 1'b0;
          nxt.relay_cnt   = nxt.relay_cnt + COUNT_BITS'(1);
        end else if (nxt.relay && nxt.phase_t == '0) begin
          nxt.relay       = 1'b0;
          nxt.phase_armed = 1'b0;
          nxt.reed_lock   = 1'b0;
        end

        // First tick of a minus press starts the hold count.
        if (minus) begin
          if (cfg.clear_hold_ms <= CFG_BITS'(1)) begin
            nxt.period    = '0;
            nxt.relay_cnt = '0;
            nxt.reed_cnt  = '0;
            nxt.hold_t    = '0;
          end else begin
            nxt.hold_t = TIMER_BITS'(1);
          end
        end else begin
          nxt.hold_t = '0;
        end

        if (save_due) begin
          strobe           = 1'b1;
          nxt.save_pending = 1'b0;
        end
      end
    end

    res.relay_on    = nxt.relay;
    res.relay_count = OUT_COUNT_BITS'(nxt.relay_cnt);
    res.reed_count  = OUT_COUNT_BITS'(nxt.reed_cnt);
    res.period_s    = nxt.period;
    res.stuck_fault = nxt.fault;
    res.save_strobe = strobe;
  end

endmodule

`default_nettype wire

@@ sv/relay_cycle_tester_controller.sv @@
// Top level of the relay cycle tester controller: input register, state
// register, result register and handshake. Uses rctc_pkg, rctc_cfg_regs, rctc_step.
//
//   Channel   Direction  Handshake               Payload
//   in        sink       in_valid / in_stall     plus_button, minus_button, reed_level
//   out       source     out_valid / out_stall   relay_on, relay_count, reed_count,
//                                                period_s, stuck_fault, save_strobe
//   cfg       sink       cfg_write               cfg_index, cfg_data
//
// Each tick item passes through the input register and then the result register,
// and a new item can be transferred in every cycle while the result is not
// stalled.
// Reset (rst, synchronous) loads the register defaults, zeroes all state and
// empties both the input and the result register.
// A stalled result holds the result register; the input register then holds
// its item and in_stall rises, so no tick is lost or repeated.
`default_nettype none

module relay_cycle_tester_controller
  import rctc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      plus_button,
  input  wire logic                      minus_button,
  input  wire logic                      reed_level,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           relay_on,
  output logic [OUT_COUNT_BITS-1:0]      relay_count,
  output logic [OUT_COUNT_BITS-1:0]      reed_count,
  output logic [PERIOD_BITS-1:0]         period_s,
  output logic                           stuck_fault,
  output logic                           save_strobe
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  result_t step_res;
  result_t res;

  // Input register holding one tick's pin levels.
  logic in_full;
  logic in_plus;
  logic in_minus;
  logic in_reed;

  // The held tick advances whenever the result register is free or draining.
  logic advance;

  rctc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rctc_step u_step (
    .cfg   (cfg),
    .cur   (state),
    .plus  (in_plus),
    .minus (in_minus),
    .reed  (in_reed),
    .nxt   (state_next),
    .res   (step_res)
  );

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_plus  <= plus_button;
      in_minus <= minus_button;
      in_reed  <= reed_level;
    end
  end

  // Tick state commits together with the result it produces.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_res;
    end
  end

  assign relay_on    = res.relay_on;
  assign relay_count = res.relay_count;
  assign reed_count  = res.reed_count;
  assign period_s    = res.period_s;
  assign stuck_fault = res.stuck_fault;
  assign save_strobe = res.save_strobe;

  // State only moves when a tick is processed.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("tick state changed without a processed tick");

  // A delivered result shows the state committed with it.
  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> (res.period_s == state.period) && (res.relay_on == state.relay) &&
                (res.stuck_fault == state.fault))
    else $error("result register disagrees with committed state");

  // A save strobe consumes a pending save request.
  a_strobe_consumes: assert property (@(posedge clk) disable iff (rst)
    advance && step_res.save_strobe |-> state.save_pending && !state_next.save_pending)
    else $error("save strobe without a pending request");

  // The relay counter steps by at most one per tick or clears.
  a_relay_count_step: assert property (@(posedge clk) disable iff (rst)
    advance |-> (state_next.relay_cnt == state.relay_cnt) ||
                (state_next.relay_cnt == state.relay_cnt + COUNT_BITS'(1)) ||
                (state_next.relay_cnt == '0))
    else $error("relay counter jumped");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for relay_cycle_tester_controller: a short directed table,
// then random millisecond-tick streams under six register settings.
// Depends only on rctc_pkg and the block's RTL; no files, no arguments.

module tb_top;
  import rctc_pkg::*;

  localparam int ITEMS_PER_SETTING = 190;
  localparam int SETTING_COUNT     = 6;
  localparam int QUIET_LIMIT       = 4000;
  localparam int TAIL_CYCLES       = 8;
  localparam logic [15:0] TIMER_TOP = 16'hFFFF;

  // One row of the directed table: either a tick transfer or a register write.
  typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        plus;
    logic        minus;
    logic        reed;
    cfg_index_t  idx;
    logic [15:0] value;
    logic        fixed;
    result_t     want;
  } plan_row_t;

  // Clock, reset and every block input start at known values.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        plus_button = 1'b0;
  logic        minus_button = 1'b0;
  logic        reed_level = 1'b0;
  logic        out_stall = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic        relay_on;
  logic [31:0] relay_count;
  logic [31:0] reed_count;
  logic [5:0]  period_s;
  logic        stuck_fault;
  logic        save_strobe;

  relay_cycle_tester_controller u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .plus_button  (plus_button),
    .minus_button (minus_button),
    .reed_level   (reed_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .relay_on     (relay_on),
    .relay_count  (relay_count),
    .reed_count   (reed_count),
    .period_s     (period_s),
    .stuck_fault  (stuck_fault),
    .save_strobe  (save_strobe)
  );

  // 12-unit clock period: six high, six low.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Controller model. These variables mirror the block's settings and state and
  // are advanced once per accepted tick transfer. Values here are the reset ones.
  // ---------------------------------------------------------------------------
  cfg_t cfg_now = '{pulse_ms: 16'd500, button_guard_ms: 16'd200,
                    adjust_holdoff_ms: 16'd5000, reed_guard_ms: 16'd500,
                    stuck_timeout_ms: 16'd5000, clear_hold_ms: 16'd5000,
                    save_delay_ms: 16'd4000, max_period_s: 6'd30};

  logic [5:0]  sel_period = '0;
  logic        relay_lvl = 1'b0;
  logic        phase_loaded = 1'b0;
  logic [31:0] pulse_total = '0;
  logic [31:0] reed_total = '0;
  logic [15:0] phase_left = '0;
  logic [15:0] plus_guard_left = '0;
  logic [15:0] minus_guard_left = '0;
  logic        plus_locked = 1'b0;
  logic        minus_locked = 1'b0;
  logic [15:0] holdoff_left = '0;
  logic [15:0] reed_guard_left = '0;
  logic        reed_cycle_done = 1'b0;
  logic [15:0] stuck_left = '0;
  logic        stuck_watch = 1'b0;
  logic        fault_flag = 1'b0;
  logic [15:0] minus_held_ms = '0;
  logic [15:0] save_left = '0;
  logic        save_wanted = 1'b0;

  // Figures for the closing summary.
  int clears_predicted = 0;
  int pulses_predicted = 0;
  int faults_predicted = 0;
  int strobes_predicted = 0;
  int settings_used = 0;

  function automatic logic [15:0] tick_down(input logic [15:0] t);
    return (t == 16'd0) ? 16'd0 : t - 16'd1;
  endfunction

  function automatic result_t current_outputs(input logic strobe);
    result_t res;
    res.relay_on    = relay_lvl;
    res.relay_count = pulse_total;
    res.reed_count  = reed_total;
    res.period_s    = sel_period;
    res.stuck_fault = fault_flag;
    res.save_strobe = strobe;
    return res;
  endfunction

  // A period change pauses pulsing and counting and rearms the save request.
  task automatic note_adjustment();
    holdoff_left = cfg_now.adjust_holdoff_ms;
    save_left    = cfg_now.save_delay_ms;
    save_wanted  = 1'b1;
  endtask

  // One millisecond tick of the controller.
  task automatic tick_model(input logic p, input logic m, input logic r,
                            output result_t res);
    logic        save_now;
    int unsigned off_ms;
    save_now = save_wanted && (save_left == 16'd0);

    phase_left       = tick_down(phase_left);
    plus_guard_left  = tick_down(plus_guard_left);
    minus_guard_left = tick_down(minus_guard_left);
    holdoff_left     = tick_down(holdoff_left);
    reed_guard_left  = tick_down(reed_guard_left);
    stuck_left       = tick_down(stuck_left);
    save_left        = tick_down(save_left);

    // While minus stays held past its first tick only the timers and the hold count move.
    if (m && minus_held_ms != 16'd0) begin
      if (minus_held_ms != TIMER_TOP) minus_held_ms++;
      if (minus_held_ms >= cfg_now.clear_hold_ms) begin
        sel_period = '0;
        pulse_total = '0;
        reed_total = '0;
        minus_held_ms = '0;
        clears_predicted++;
      end
      res = current_outputs(1'b0);
      return;
    end
    if (fault_flag && r && sel_period != '0) begin
      res = current_outputs(1'b0);
      return;
    end

    if (p && !plus_locked) begin
      if ({1'b0, sel_period} + 7'd1 > {1'b0, cfg_now.max_period_s})
        sel_period = cfg_now.max_period_s;
      else
        sel_period = sel_period + 6'd1;
      plus_guard_left = cfg_now.button_guard_ms;
      plus_locked = 1'b1;
      note_adjustment();
      save_now = 1'b0;
    end
    // Plus unlocks only once released; minus unlocks even while held.
    if (plus_guard_left == 16'd0 && !p) plus_locked = 1'b0;
    if (m && !minus_locked) begin
      if (sel_period != '0) sel_period = sel_period - 6'd1;
      minus_guard_left = cfg_now.button_guard_ms;
      minus_locked = 1'b1;
      note_adjustment();
      save_now = 1'b0;
    end
    if (minus_guard_left == 16'd0) minus_locked = 1'b0;
    if (sel_period > cfg_now.max_period_s) sel_period = cfg_now.max_period_s;

    if (r && reed_guard_left == 16'd0 && sel_period != '0 && holdoff_left == 16'd0 &&
        !reed_cycle_done) begin
      reed_total = reed_total + 32'd1;
      reed_guard_left = cfg_now.reed_guard_ms;
      reed_cycle_done = 1'b1;
    end

    if (r && !stuck_watch && sel_period != '0) begin
      stuck_left = cfg_now.stuck_timeout_ms;
      stuck_watch = 1'b1;
    end else if (!r) begin
      stuck_left = '0;
      stuck_watch = 1'b0;
      fault_flag = 1'b0;
    end
    if (r && stuck_watch && stuck_left == 16'd0) fault_flag = 1'b1;
    if (fault_flag && r && sel_period != '0) begin
      res = current_outputs(1'b0);
      return;
    end

    // The phase timer is loaded on the tick after each relay edge.
    if (!phase_loaded) begin
      off_ms = sel_period * MS_PER_SECOND;
      if (relay_lvl)
        phase_left = cfg_now.pulse_ms;
      else
        phase_left = (off_ms > 32'(TIMER_TOP)) ? TIMER_TOP : off_ms[15:0];
      phase_loaded = 1'b1;
    end
    if (!relay_lvl && phase_left == 16'd0 && sel_period != '0 && holdoff_left == 16'd0) begin
      relay_lvl = 1'b1;
      phase_loaded = 1'b0;
      pulse_total = pulse_total + 32'd1;
    end else if (relay_lvl && phase_left == 16'd0) begin
      relay_lvl = 1'b0;
      phase_loaded = 1'b0;
      reed_cycle_done = 1'b0;
    end

    if (m) begin
      minus_held_ms = 16'd1;
      if (minus_held_ms >= cfg_now.clear_hold_ms) begin
        sel_period = '0;
        pulse_total = '0;
        reed_total = '0;
        minus_held_ms = '0;
        clears_predicted++;
      end
    end else begin
      minus_held_ms = '0;
    end

    if (save_now) save_wanted = 1'b0;
    res = current_outputs(save_now);
  endtask

  // ---------------------------------------------------------------------------
  // Traffic shaping. Percentages are changed by the stimulus process; a calm
  // stretch suppresses idling for a while on that side.
  // ---------------------------------------------------------------------------
  int tx_idle_pct = 25;
  int rx_stall_pct = 88;
  int tx_calm = 0;
  int rx_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (rx_calm != 0) begin
      rx_calm <= rx_calm - 1;
      out_stall <= 1'b0;
    end else if ($urandom_range(199) == 0) begin
      rx_calm <= $urandom_range(60, 20);
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard. Both handshakes are sampled right after the rising edge, when
  // signals still hold the values the block saw at that edge. A tick transfer
  // is run through the model; a result transfer is compared with the oldest
  // prediction still waiting.
  // ---------------------------------------------------------------------------
  logic    typed_flag_q [$];
  result_t typed_want_q [$];
  result_t pending_results [$];
  int      accepted_ticks = 0;
  int      results_checked = 0;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  logic    last_relay = 1'b0;
  logic    last_fault = 1'b0;

  always @(posedge clk) begin : scoreboard
    result_t want;
    result_t got;
    result_t typed;
    logic    fixed_now;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        tick_model(plus_button, minus_button, reed_level, want);
        fixed_now = typed_flag_q.pop_front();
        typed = typed_want_q.pop_front();
        // Directed rows with a hand-written result are held to that value.
        if (fixed_now) want = typed;
        if (want.relay_on && !last_relay) pulses_predicted++;
        if (want.stuck_fault && !last_fault) faults_predicted++;
        if (want.save_strobe) strobes_predicted++;
        last_relay = want.relay_on;
        last_fault = want.stuck_fault;
        pending_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got.relay_on    = relay_on;
        got.relay_count = relay_count;
        got.reed_count  = reed_count;
        got.period_s    = period_s;
        got.stuck_fault = stuck_fault;
        got.save_strobe = save_strobe;
        results_checked++;
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("Result transfer %0d arrived with no tick waiting for it",
                     results_checked);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.relay_on !== want.relay_on || got.relay_count !== want.relay_count ||
              got.reed_count !== want.reed_count || got.period_s !== want.period_s ||
              got.stuck_fault !== want.stuck_fault ||
              got.save_strobe !== want.save_strobe) begin
            if (mismatches < 10) begin
              $display("Mismatch on result %0d: expected relay=%0b pulses=%0d reeds=%0d",
                       results_checked, want.relay_on, want.relay_count, want.reed_count,
                       " period=%0d fault=%0b save=%0b",
                       want.period_s, want.stuck_fault, want.save_strobe);
              $display("  got relay=%0b pulses=%0d reeds=%0d period=%0d fault=%0b save=%0b",
                       got.relay_on, got.relay_count, got.reed_count, got.period_s,
                       got.stuck_fault, got.save_strobe);
            end
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: %0d cycles without a transfer", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Offer one tick, with an optional sender gap first, and wait for its transfer.
  task automatic send_tick(input logic p, input logic m, input logic r,
                           input logic fixed, input result_t want);
    typed_flag_q.push_back(fixed);
    typed_want_q.push_back(want);
    if (tx_calm != 0) begin
      tx_calm--;
    end else if ($urandom_range(149) == 0) begin
      tx_calm = $urandom_range(60, 20);
    end else begin
      while ($urandom_range(99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    plus_button  <= p;
    minus_button <= m;
    reed_level   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accepted_ticks++;
  endtask

  // Stop sending and wait until every tick has produced its result, then let
  // the pipeline settle.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (results_checked < accepted_ticks) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes happen only with the block drained; the model copy of the
  // settings follows each write.
  task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PULSE_MS:          cfg_now.pulse_ms = value;
      REG_BUTTON_GUARD_MS:   cfg_now.button_guard_ms = value;
      REG_ADJUST_HOLDOFF_MS: cfg_now.adjust_holdoff_ms = value;
      REG_REED_GUARD_MS:     cfg_now.reed_guard_ms = value;
      REG_STUCK_TIMEOUT_MS:  cfg_now.stuck_timeout_ms = value;
      REG_CLEAR_HOLD_MS:     cfg_now.clear_hold_ms = value;
      REG_SAVE_DELAY_MS:     cfg_now.save_delay_ms = value;
      REG_MAX_PERIOD_S:      cfg_now.max_period_s = value[5:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Load a whole setting. Spare upper bits of the period clamp word carry noise,
  // which the block must ignore.
  task automatic apply_settings(input cfg_t s);
    wait_for_results();
    write_reg(REG_PULSE_MS, s.pulse_ms);
    write_reg(REG_BUTTON_GUARD_MS, s.button_guard_ms);
    write_reg(REG_ADJUST_HOLDOFF_MS, s.adjust_holdoff_ms);
    write_reg(REG_REED_GUARD_MS, s.reed_guard_ms);
    write_reg(REG_STUCK_TIMEOUT_MS, s.stuck_timeout_ms);
    write_reg(REG_CLEAR_HOLD_MS, s.clear_hold_ms);
    write_reg(REG_SAVE_DELAY_MS, s.save_delay_ms);
    write_reg(REG_MAX_PERIOD_S, {10'($urandom()), s.max_period_s});
    settings_used++;
  endtask

  function automatic plan_row_t tick_row(input logic p, input logic m, input logic r,
                                         input logic fixed, input result_t want);
    plan_row_t row;
    row = '0;
    row.kind  = ROW_TICK;
    row.plus  = p;
    row.minus = m;
    row.reed  = r;
    row.fixed = fixed;
    row.want  = want;
    return row;
  endfunction

  function automatic plan_row_t reg_row(input cfg_index_t idx, input logic [15:0] value);
    plan_row_t row;
    row = '0;
    row.kind  = ROW_REG;
    row.idx   = idx;
    row.value = value;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t plan [$];
    plan_row_t row;
    cfg_t      phase_cfg [SETTING_COUNT];
    logic      p, m, r;
    int        plus_run, minus_run, reed_run;
    logic      plus_lvl, minus_lvl, reed_lvl;
    int        lim;

    plus_run = 0;
    minus_run = 0;
    reed_run = 0;
    plus_lvl = 1'b0;
    minus_lvl = 1'b0;
    reed_lvl = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The first two ticks run on reset settings and cannot move
    // anything: no button is pressed and a reed pulse with a zero period is
    // neither counted nor supervised, so every output is zero.
    plan.push_back(tick_row(1'b0, 1'b0, 1'b0, 1'b1, '0));
    plan.push_back(tick_row(1'b0, 1'b0, 1'b1, 1'b1, '0));
    // Shortest legal timings and a clamp of two seconds.
    plan.push_back(reg_row(REG_PULSE_MS, 16'd1));
    plan.push_back(reg_row(REG_BUTTON_GUARD_MS, 16'd0));
    plan.push_back(reg_row(REG_ADJUST_HOLDOFF_MS, 16'd0));
    plan.push_back(reg_row(REG_REED_GUARD_MS, 16'd0));
    plan.push_back(reg_row(REG_STUCK_TIMEOUT_MS, 16'd1));
    plan.push_back(reg_row(REG_CLEAR_HOLD_MS, 16'd3));
    plan.push_back(reg_row(REG_SAVE_DELAY_MS, 16'd0));
    plan.push_back(reg_row(REG_MAX_PERIOD_S, 16'd2));
    // Plus press starts a pulse at once, held plus stays locked, save strobe
    // follows, and steps saturate at the clamp.
    plan.push_back(tick_row(1'b1, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(tick_row(1'b0, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(tick_row(1'b0, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b0, 1'b0, '0));
    // Reed event, then a reed held high long enough to raise and hold the
    // stuck fault, then released to clear it.
    plan.push_back(tick_row(1'b0, 1'b0, 1'b1, 1'b0, '0));
    plan.push_back(tick_row(1'b0, 1'b0, 1'b1, 1'b0, '0));
    plan.push_back(tick_row(1'b0, 1'b0, 1'b1, 1'b0, '0));
    plan.push_back(tick_row(1'b0, 1'b0, 1'b0, 1'b0, '0));
    // Minus held: first tick steps down, then frozen ticks until the hold clears
    // period and counters, then a normal tick that saturates at zero.
    plan.push_back(tick_row(1'b0, 1'b1, 1'b0, 1'b0, '0));
    plan.push_back(tick_row(1'b0, 1'b1, 1'b0, 1'b0, '0));
    plan.push_back(tick_row(1'b0, 1'b1, 1'b0, 1'b0, '0));
    plan.push_back(tick_row(1'b0, 1'b1, 1'b0, 1'b0, '0));
    plan.push_back(tick_row(1'b0, 1'b0, 1'b0, 1'b0, '0));
    // Raise the period to two, then lower the clamp below it.
    plan.push_back(reg_row(REG_MAX_PERIOD_S, 16'd63));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(tick_row(1'b0, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(reg_row(REG_MAX_PERIOD_S, 16'd1));
    plan.push_back(tick_row(1'b0, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(tick_row(1'b1, 1'b1, 1'b1, 1'b0, '0));

    settings_used++;
    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REG) begin
        wait_for_results();
        write_reg(row.idx, row.value);
      end else begin
        send_tick(row.plus, row.minus, row.reed, row.fixed, row.want);
      end
    end

    // Settings for the random part: quick timings, the lowest legal values,
    // two random small sets, the highest values and a middle set.
    phase_cfg[0] = '{pulse_ms: 16'd3, button_guard_ms: 16'd2, adjust_holdoff_ms: 16'd5,
                     reed_guard_ms: 16'd4, stuck_timeout_ms: 16'd25, clear_hold_ms: 16'd30,
                     save_delay_ms: 16'd8, max_period_s: 6'd2};
    phase_cfg[1] = '{pulse_ms: 16'd1, button_guard_ms: 16'd0, adjust_holdoff_ms: 16'd0,
                     reed_guard_ms: 16'd0, stuck_timeout_ms: 16'd1, clear_hold_ms: 16'd1,
                     save_delay_ms: 16'd0, max_period_s: 6'd1};
    phase_cfg[3] = '{pulse_ms: 16'hFFFF, button_guard_ms: 16'hFFFF,
                     adjust_holdoff_ms: 16'hFFFF, reed_guard_ms: 16'hFFFF,
                     stuck_timeout_ms: 16'hFFFF, clear_hold_ms: 16'hFFFF,
                     save_delay_ms: 16'hFFFF, max_period_s: 6'd63};
    phase_cfg[4] = '{pulse_ms: 16'd50, button_guard_ms: 16'd20, adjust_holdoff_ms: 16'd100,
                     reed_guard_ms: 16'd30, stuck_timeout_ms: 16'd90, clear_hold_ms: 16'd120,
                     save_delay_ms: 16'd60, max_period_s: 6'd5};
    foreach (phase_cfg[i]) begin
      if (i == 2 || i == 5) begin
        phase_cfg[i].pulse_ms          = 16'($urandom_range(20, 1));
        phase_cfg[i].button_guard_ms   = 16'($urandom_range(10, 0));
        phase_cfg[i].adjust_holdoff_ms = 16'($urandom_range(30, 0));
        phase_cfg[i].reed_guard_ms     = 16'($urandom_range(20, 0));
        phase_cfg[i].stuck_timeout_ms  = 16'($urandom_range(60, 1));
        phase_cfg[i].clear_hold_ms     = 16'($urandom_range(80, 1));
        phase_cfg[i].save_delay_ms     = 16'($urandom_range(40, 0));
        phase_cfg[i].max_period_s      = 6'($urandom_range(63, 1));
      end
    end

    // Random part. Each button and the reed follow runs of random length so
    // that presses, releases, long minus holds and stuck reeds all occur; a
    // share of ticks is pure noise on all three pins.
    for (int ph = 0; ph < SETTING_COUNT; ph++) begin
      if (ph < 2) begin
        tx_idle_pct = 25;
        rx_stall_pct = 88;
      end else if (ph < 4) begin
        tx_idle_pct = 88;
        rx_stall_pct = 25;
      end else begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      apply_settings(phase_cfg[ph]);
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        // Halfway through, the sender pauses until every result is back.
        if (n == ITEMS_PER_SETTING / 2) wait_for_results();
        if (plus_run == 0) begin
          plus_lvl = !plus_lvl;
          lim = (cfg_now.button_guard_ms + 3 > 30) ? 30 : cfg_now.button_guard_ms + 3;
          plus_run = plus_lvl ? $urandom_range(lim, 1) : $urandom_range(40, 1);
        end
        if (minus_run == 0) begin
          minus_lvl = !minus_lvl;
          lim = (cfg_now.clear_hold_ms + 3 > 250) ? 250 : cfg_now.clear_hold_ms + 3;
          if (!minus_lvl)
            minus_run = $urandom_range(40, 1);
          else if ($urandom_range(5) == 0)
            minus_run = lim;
          else
            minus_run = $urandom_range(5, 1);
        end
        if (reed_run == 0) begin
          reed_lvl = !reed_lvl;
          lim = (cfg_now.stuck_timeout_ms + 6 > 150) ? 150 : cfg_now.stuck_timeout_ms + 6;
          if (!reed_lvl)
            reed_run = $urandom_range(60, 1);
          else if ($urandom_range(4) == 0)
            reed_run = $urandom_range(lim, 1);
          else
            reed_run = $urandom_range(6, 1);
        end
        plus_run--;
        minus_run--;
        reed_run--;
        if ($urandom_range(99) < 12) begin
          {p, m, r} = 3'($urandom());
        end else begin
          p = plus_lvl;
          m = minus_lvl;
          r = reed_lvl;
        end
        send_tick(p, m, r, 1'b0, '0);
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d predicted results never arrived", pending_results.size());
      mismatches += pending_results.size();
    end

    $display("Run covered %0d tick transfers under %0d register settings and three idle mixes.",
             accepted_ticks, settings_used);
    $display("Model saw %0d relay pulses, %0d stuck faults, %0d save strobes, %0d clears.",
             pulses_predicted, faults_predicted, strobes_predicted, clears_predicted);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rctc_pkg.sv
sv/rctc_cfg_regs.sv
sv/rctc_step.sv
sv/relay_cycle_tester_controller.sv
bench/tb_top.sv
